/* hw/rtl/bounded_stack_with_stats_unit_macros.svh */
// Assertion macros shared by the stack RTL.
`ifndef BOUNDED_STACK_WITH_STATS_UNIT_MACROS_SVH
`define BOUNDED_STACK_WITH_STATS_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define BSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/bss_pkg.sv */
// Package: constants, codes and transaction types of the bounded stack.
package bss_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] push_value;
    } bss_in_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [1:0]         status;
        logic               is_empty;
        logic [7:0]         depth;
        logic [31:0]        push_count;
        logic [31:0]        pop_count;
        logic [7:0]         max_depth;
    } bss_out_t;

    typedef struct packed {
        logic            push_ok;
        logic            pop_ok;
        logic [SP_W-1:0] sp_next;
    } bss_stat_evt_t;

endpackage

/* hw/rtl/bss_store.sv */
// Word store: synchronous RAM with separate write and read ports, registered read.
module bss_store (
    input  logic                      clk,
    input  logic                      we,
    input  logic [bss_pkg::ADDR_W-1:0] waddr,
    input  logic [31:0]               wdata,
    input  logic                      re,
    input  logic [bss_pkg::ADDR_W-1:0] raddr,
    output logic [31:0]               rdata
);
    import bss_pkg::*;

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bss_stats.sv */
// Running statistics: saturating push/pop counters and high-water depth.
module bss_stats (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bss_pkg::bss_stat_evt_t evt,
    output logic [31:0]            push_count,
    output logic [31:0]            pop_count,
    output logic [bss_pkg::SP_W-1:0] max_depth
);
    import bss_pkg::*;

    `include "bounded_stack_with_stats_unit_macros.svh"

    logic [31:0]     push_cnt_reg, push_cnt_next;
    logic [31:0]     pop_cnt_reg, pop_cnt_next;
    logic [SP_W-1:0] high_water_reg, high_water_next;

    always_comb
    begin
        push_cnt_next   = push_cnt_reg;
        pop_cnt_next    = pop_cnt_reg;
        high_water_next = high_water_reg;
        if (evt.push_ok && (push_cnt_reg != '1))
        begin
            push_cnt_next = push_cnt_reg + 32'd1;
        end
        if (evt.pop_ok && (pop_cnt_reg != '1))
        begin
            pop_cnt_next = pop_cnt_reg + 32'd1;
        end
        if (evt.push_ok && (evt.sp_next > high_water_reg))
        begin
            high_water_next = evt.sp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_cnt_reg   <= '0;
            pop_cnt_reg    <= '0;
            high_water_reg <= '0;
        end
        else
        begin
            push_cnt_reg   <= push_cnt_next;
            pop_cnt_reg    <= pop_cnt_next;
            high_water_reg <= high_water_next;
        end
    end

    assign push_count = push_cnt_reg;
    assign pop_count  = pop_cnt_reg;
    assign max_depth  = high_water_reg;

    // high water only grows; saturated counters stay put
    `BSS_ASSERT_NEXT(a_hw_mono, 1'b1, high_water_reg >= $past(high_water_reg))
    `BSS_ASSERT_NEXT(a_push_sat, push_cnt_reg == '1, push_cnt_reg == '1)
    `BSS_ASSERT_NEXT(a_pop_sat, pop_cnt_reg == '1, pop_cnt_reg == '1)

endmodule

/* hw/rtl/bounded_stack_with_stats_unit.sv */
// Top level: bounded LIFO stack of signed words with running statistics.
//
//  channel  | handshake          | payload (bss_pkg)  | direction
//  ---------+--------------------+--------------------+----------
//  command  | start / busy       | cmd    (bss_in_t)  | in
//  result   | done (strobe)      | rsp    (bss_out_t) | out
//
// A transaction is accepted at a clock edge; pending_reg registers the accept and
// drives done in the result cycle, in which the word RAM's registered read is out.
// busy is still high at the edge ending the result cycle, so the next command
// is taken only after busy falls: no new command is taken while one is pending.
// Reset (rst_n, async, active low) clears depth, statistics and the pending
// flag; the RAM contents are left as they are, only written entries are read.
// The receiver cannot stall: rsp is valid for exactly the one cycle of done.
module bounded_stack_with_stats_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bss_pkg::bss_in_t  cmd,
    output logic              done,
    output bss_pkg::bss_out_t rsp
);
    import bss_pkg::*;

    `include "bounded_stack_with_stats_unit_macros.svh"

    // Stack pointer = number of words held; pending marks the result cycle.
    logic [SP_W-1:0] sp_reg, sp_next;
    logic            pending_reg;
    logic [1:0]      status_reg, status_next;
    logic            rd_ok_reg;       // result carries a RAM word

    logic            accept;
    logic            is_push, is_pop;
    logic            full, empty;
    logic            push_ok, pop_ok, peek_ok;
    logic [SP_W-1:0] sp_m1;
    logic [31:0]     rdata;

    bss_stat_evt_t   evt;
    logic [31:0]     push_count, pop_count;
    logic [SP_W-1:0] max_depth;

    assign accept  = start && !busy;
    assign is_push = (cmd.operation == OP_PUSH);
    assign is_pop  = (cmd.operation == OP_POP);
    // any other code (bit 1 set) is a peek
    assign full    = (sp_reg == SP_W'(STACK_DEPTH));
    assign empty   = (sp_reg == '0);
    assign sp_m1   = sp_reg - SP_W'(1);

    assign push_ok = accept && is_push && !full;
    assign pop_ok  = accept && is_pop && !empty;
    assign peek_ok = accept && !is_push && !is_pop && !empty;

    always_comb
    begin
        sp_next = sp_reg;
        if (push_ok)
        begin
            sp_next = sp_reg + SP_W'(1);
        end
        else if (pop_ok)
        begin
            sp_next = sp_m1;
        end

        if (is_push)
        begin
            status_next = full ? ST_FULL : ST_OK;
        end
        else
        begin
            status_next = empty ? ST_EMPTY : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg      <= '0;
            pending_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            sp_reg      <= sp_next;
            pending_reg <= accept;
            if (accept)
            begin
                rd_ok_reg <= pop_ok || peek_ok;
            end
        end
    end

    // status is payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    // Push writes at the current pointer; pop and peek read the top entry.
    bss_store u_store (
        .clk   (clk),
        .we    (push_ok),
        .waddr (sp_reg[ADDR_W-1:0]),
        .wdata (cmd.push_value),
        .re    (pop_ok || peek_ok),
        .raddr (sp_m1[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign evt.push_ok = push_ok;
    assign evt.pop_ok  = pop_ok;
    assign evt.sp_next = sp_next;

    bss_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .push_count (push_count),
        .pop_count  (pop_count),
        .max_depth  (max_depth)
    );

    // State already reflects the accepted command during the result cycle.
    assign busy = pending_reg;
    assign done = pending_reg;

    assign rsp.top_value  = rd_ok_reg ? rdata : '0;
    assign rsp.status     = status_reg;
    assign rsp.is_empty   = (sp_reg == '0);
    assign rsp.depth      = 8'(sp_reg);
    assign rsp.push_count = push_count;
    assign rsp.pop_count  = pop_count;
    assign rsp.max_depth  = 8'(max_depth);

    `BSS_ASSERT_NEXT(a_accept_done, accept, done)
    `BSS_ASSERT_NOW(a_sp_bound, 1'b1, sp_reg <= SP_W'(STACK_DEPTH))
    `BSS_ASSERT_NOW(a_refused_hold, done && (status_reg != ST_OK), sp_reg == $past(sp_reg))

endmodule
